>>> src/dq_pkg.sv
// Package with the types, codes and sizes shared by the double-ended queue files.
package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_REAR   = 3'd3;
    localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [2:0] KIND_PEEK_REAR  = 3'd5;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
    } t_dq_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } t_dq_out;

    // Command that every cell of the row carries out.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_REAR,
        CELL_SHIFT_FRONT,
        CELL_WRITE_TAIL,
        CELL_DROP_TAIL
    } t_cell_cmd;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } t_cell_link;

endpackage

>>> src/dq_cell.sv
// One storage cell of the queue row: holds a word and its occupied flag.
module dq_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dq_pkg::t_cell_cmd               i_cmd,
    input  logic signed [dq_pkg::DATA_W-1:0] i_value,
    input  dq_pkg::t_cell_link              i_prev,
    input  dq_pkg::t_cell_link              i_next,
    output dq_pkg::t_cell_link              o_cell,
    output logic                            o_tail
);
    import dq_pkg::*;

    t_cell_link r_cell;
    t_cell_link n_cell;

    always_comb begin
        n_cell = r_cell;
        case (i_cmd)
            CELL_HOLD: begin
                n_cell = r_cell;
            end
            CELL_SHIFT_REAR: begin
                n_cell = i_prev;
            end
            CELL_SHIFT_FRONT: begin
                n_cell = i_next;
            end
            CELL_WRITE_TAIL: begin
                // The first free cell behind the occupied ones takes the word.
                if (i_prev.valid && !r_cell.valid) begin
                    n_cell.valid = 1'b1;
                    n_cell.data  = i_value;
                end
            end
            CELL_DROP_TAIL: begin
                if (r_cell.valid && !i_next.valid) begin
                    n_cell.valid = 1'b0;
                end
            end
            default: begin
                n_cell = r_cell;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
    assign o_tail = r_cell.valid && !i_next.valid;

endmodule

>>> src/double_ended_queue_unit.sv
// Top level of the double-ended queue: a row of cells with the front word in cell 0.
//
// The queue takes one operation in every clock cycle and never raises busy; the
// result appears on o_result with o_valid high for one cycle, in the cycle right
// after the operation was taken, and the rate is one operation per cycle. Words
// sit in a row of DEPTH cells, front word first: a push at the front or a pop at
// the front moves the whole row by one cell, while a push at the rear fills only
// the first free cell and a pop at the rear clears only the last occupied cell. No
// clearing pass follows reset; the queue is empty as soon as reset is released.
module double_ended_queue_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  dq_pkg::t_dq_in  i_item,
    output logic            o_valid,
    output dq_pkg::t_dq_out o_result
);
    import dq_pkg::*;

    t_cell_link         links [DEPTH];
    logic               tails [DEPTH];
    t_cell_cmd          cell_cmd;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_valid;
    t_dq_out            r_result;
    t_dq_out            n_result;
    logic [DATA_W-1:0]  rear_data;
    logic               fire;
    logic               full;
    logic               empty;

    assign busy  = 1'b0;
    assign fire  = start && !busy;
    assign full  = (r_count == COUNT_W'(DEPTH));
    assign empty = (r_count == '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_cell_link prev_link;
            t_cell_link next_link;
            if (gi == 0) begin : g_first
                assign prev_link = '{valid: 1'b1, data: i_item.value};
            end else begin : g_mid
                assign prev_link = links[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign next_link = '0;
            end else begin : g_inner
                assign next_link = links[gi+1];
            end
            dq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cell_cmd),
                .i_value (i_item.value),
                .i_prev  (prev_link),
                .i_next  (next_link),
                .o_cell  (links[gi]),
                .o_tail  (tails[gi])
            );
        end
    endgenerate

    // Exactly one cell is the tail when the queue is not empty.
    always_comb begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_data = rear_data | (tails[i] ? links[i].data : '0);
        end
    end

    always_comb begin
        cell_cmd        = CELL_HOLD;
        n_count         = r_count;
        n_result.data   = '0;
        n_result.status = STATUS_OK;
        case (i_item.kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                if (full) begin
                    n_result.status = STATUS_FULL;
                end else begin
                    cell_cmd = (i_item.kind == KIND_PUSH_FRONT) ? CELL_SHIFT_REAR
                                                                : CELL_WRITE_TAIL;
                    n_count  = r_count + 1'b1;
                end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT: begin
                if (empty) begin
                    n_result.data   = '1;
                    n_result.status = STATUS_EMPTY;
                end else begin
                    n_result.data = links[0].data;
                    if (i_item.kind == KIND_POP_FRONT) begin
                        cell_cmd = CELL_SHIFT_FRONT;
                        n_count  = r_count - 1'b1;
                    end
                end
            end
            KIND_POP_REAR, KIND_PEEK_REAR: begin
                if (empty) begin
                    n_result.data   = '1;
                    n_result.status = STATUS_EMPTY;
                end else begin
                    n_result.data = rear_data;
                    if (i_item.kind == KIND_POP_REAR) begin
                        cell_cmd = CELL_DROP_TAIL;
                        n_count  = r_count - 1'b1;
                    end
                end
            end
            default: begin
                cell_cmd = CELL_HOLD;
            end
        endcase
        n_result.count    = n_count;
        n_result.is_empty = (n_count == '0);
        if (!fire) begin
            cell_cmd = CELL_HOLD;
            n_count  = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> src/dq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
module dq_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input dq_pkg::t_dq_in  i_item,
    input logic            o_valid,
    input dq_pkg::t_dq_out o_result
);
    import dq_pkg::*;

    // Every transaction produces its result in the following cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("result missing one cycle after a transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without a transaction");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.is_empty == (o_result.count == '0)))
        else $error("empty flag disagrees with count");

    a_status_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == STATUS_FULL) |-> (o_result.count == COUNT_W'(DEPTH)))
        else $error("full status with a queue that is not full");

    a_status_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == STATUS_EMPTY)
            |-> (o_result.count == '0 && o_result.data == '1))
        else $error("empty status with wrong count or data");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);
